// ----- rtl/core/qhdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhdm_pkg - shared types and constants of the quadratic hull minimizer
// Field widths, store sizing, breakpoint sentinels and the structs that pass
// between the front queue, the sequencer and the divider.
// ----------------------------------------------------------------------------
package qhdm_pkg;

  // store sizing
  localparam int MAX_LINES = 1024;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  // field widths
  localparam int HEIGHT_W  = 20;
  localparam int COST_W    = 62;
  localparam int STEP_W    = 40;
  localparam int BP_W      = 64;
  localparam int SQ_W      = 2 * HEIGHT_W;
  localparam int DEN_W     = HEIGHT_W + 2;
  localparam int SUM_W     = COST_W + 1;
  localparam int DCNT_W    = $clog2(BP_W + 1);

  localparam logic [COST_W-1:0]      COST_MAX = {COST_W{1'b1}};
  // +INF is the largest signed value, -INF its negation
  localparam logic signed [BP_W-1:0] BP_INF   = {1'b0, {(BP_W-1){1'b1}}};
  localparam logic signed [BP_W-1:0] BP_NINF  = {1'b1, {(BP_W-2){1'b0}}, 1'b1};

  typedef struct packed {
    logic                start_req;
    logic [HEIGHT_W-1:0] height;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              overflow;
  } out_t;

  // classified item as held in the queue
  typedef struct packed {
    logic                restart;
    logic [HEIGHT_W-1:0] height;
  } qitem_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } queue_t;

  typedef struct packed {
    logic                    start;
    logic signed [BP_W-1:0]  num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [BP_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/qhdm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhdm_front - input side
// Takes items on the start/busy handshake, tags restart items and holds them
// in a two-entry queue until the sequencer pops them.
// ----------------------------------------------------------------------------
module qhdm_front import qhdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  output logic      busy,
  output queue_t    q,
  input  wire logic pop
);

  qitem_t     ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;

  assign busy   = (fill_r == 2'd2);
  assign push   = start && !busy;
  assign q.valid = (fill_r != 2'd0);
  assign q.item  = ent_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && q.valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !(pop && q.valid)) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && pop && q.valid) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // classify on entry: restart tag and height
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r].restart <= in_data.start_req;
      ent_r[wr_ptr_r].height  <= in_data.height;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qhdm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhdm_div - floored signed divider
// Restoring division of magnitudes, one quotient bit per cycle, then the
// sign and floor correction as a final step.
// ----------------------------------------------------------------------------
module qhdm_div import qhdm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              run_r, run_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [BP_W-1:0]   dvd_r, dvd_nxt;
  logic [DEN_W-1:0]  dsr_r, dsr_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic              neg_r, neg_nxt;
  logic signed [BP_W-1:0] quo_r, quo_nxt;

  logic [DEN_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, dvd_r[BP_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      // load magnitudes
      run_nxt = 1'b1;
      cnt_nxt = DCNT_W'(BP_W);
      dvd_nxt = req.num[BP_W-1] ? BP_W'(-req.num) : BP_W'(req.num);
      dsr_nxt = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
      rem_nxt = '0;
      neg_nxt = req.num[BP_W-1] ^ req.den[DEN_W-1];
    end else if (run_r) begin
      if (cnt_r != '0) begin
        // one quotient bit
        rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, dsr_r}) : DEN_W'(rem_sh);
        dvd_nxt = {dvd_r[BP_W-2:0], ge};
        cnt_nxt = cnt_r - DCNT_W'(1);
      end else begin
        // sign, and round toward minus infinity
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          quo_nxt = -$signed(dvd_r) - ((rem_r != '0) ? BP_W'(1) : BP_W'(0));
        end else begin
          quo_nxt = $signed(dvd_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/qhdm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhdm_back - hull sequencer
// Owns the sorted parabola store. Runs the query scan, the sorted insert,
// breakpoint evaluation through the divider and the pruning walks.
// ----------------------------------------------------------------------------
module qhdm_back import qhdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire queue_t            q,
  output logic                   pop,
  input  wire logic [STEP_W-1:0] step_cost,
  output logic                   out_valid,
  output out_t                   out_data
);

  typedef enum logic [26:0] {
    S_IDLE    = 27'd1 << 0,
    S_Q_RD    = 27'd1 << 1,
    S_Q_CHK   = 27'd1 << 2,
    S_Q_MUL   = 27'd1 << 3,
    S_Q_SUM   = 27'd1 << 4,
    S_F_RD    = 27'd1 << 5,
    S_F_CHK   = 27'd1 << 6,
    S_SH      = 27'd1 << 7,
    S_SH_WR   = 27'd1 << 8,
    S_M_START = 27'd1 << 9,
    S_M_RI    = 27'd1 << 10,
    S_M_RJ    = 27'd1 << 11,
    S_M_CALC  = 27'd1 << 12,
    S_M_NUM   = 27'd1 << 13,
    S_M_DIV   = 27'd1 << 14,
    S_M_FIN   = 27'd1 << 15,
    S_D_LOOP  = 27'd1 << 16,
    S_D_WR    = 27'd1 << 17,
    S_A_MEET  = 27'd1 << 18,
    S_A_CHK   = 27'd1 << 19,
    S_B_BEG   = 27'd1 << 20,
    S_B_CHK   = 27'd1 << 21,
    S_B_M2    = 27'd1 << 22,
    S_C_BEG   = 27'd1 << 23,
    S_C_RB    = 27'd1 << 24,
    S_C_CMP   = 27'd1 << 25,
    S_C_M     = 27'd1 << 26
  } state_t;

  // store
  logic [HEIGHT_W-1:0]    hgt_mem [MAX_LINES];
  logic [COST_W-1:0]      cst_mem [MAX_LINES];
  logic signed [BP_W-1:0] bp_mem  [MAX_LINES];

  logic [IDX_W-1:0]       raddr, waddr;
  logic                   we_all, we_bp;
  logic [HEIGHT_W-1:0]    wh;
  logic [COST_W-1:0]      wc;
  logic signed [BP_W-1:0] wbp;
  logic [HEIGHT_W-1:0]    rd_h_r;
  logic [COST_W-1:0]      rd_c_r;
  logic signed [BP_W-1:0] rd_bp_r;

  // control
  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // working registers
  out_t                   out_data_r, out_data_nxt;
  logic [HEIGHT_W-1:0]    h_r, h_nxt;
  logic [IDX_W-1:0]       i_r, i_nxt;
  logic [IDX_W-1:0]       k_r, k_nxt;
  logic [IDX_W-1:0]       s_r, s_nxt;
  logic [IDX_W-1:0]       x_r, x_nxt;
  logic [IDX_W-1:0]       y_r, y_nxt;
  logic [IDX_W-1:0]       p_r, p_nxt;
  logic [IDX_W-1:0]       mi_r, mi_nxt;
  logic [CNT_W-1:0]       mj_r, mj_nxt;
  logic signed [HEIGHT_W:0] d_r, d_nxt;
  logic [COST_W-1:0]      cbase_r, cbase_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [COST_W-1:0]      ins_dp_r, ins_dp_nxt;
  logic [HEIGHT_W-1:0]    ei_h_r, ei_h_nxt, ej_h_r, ej_h_nxt;
  logic [COST_W-1:0]      ei_c_r, ei_c_nxt, ej_c_r, ej_c_nxt;
  logic signed [BP_W-1:0] ej_bp_r, ej_bp_nxt;
  logic [SQ_W-1:0]        sqi_r, sqi_nxt, sqj_r, sqj_nxt;
  logic signed [BP_W-1:0] bpn_r, bpn_nxt;
  logic                   m_ge_r, m_ge_nxt;
  logic signed [BP_W-1:0] cmp_a_r, cmp_a_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SUM_W-1:0]         sum;
  logic signed [2*HEIGHT_W+1:0] dsq;
  logic signed [HEIGHT_W:0] hdiff;

  assign sum   = SUM_W'(sq_r) + SUM_W'(cbase_r) + SUM_W'(step_cost);
  assign dsq   = d_r * d_r;
  assign hdiff = $signed({1'b0, ei_h_r}) - $signed({1'b0, ej_h_r});

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  qhdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    h_nxt         = h_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    p_nxt         = p_r;
    mi_nxt        = mi_r;
    mj_nxt        = mj_r;
    d_nxt         = d_r;
    cbase_nxt     = cbase_r;
    sq_nxt        = sq_r;
    ins_dp_nxt    = ins_dp_r;
    ei_h_nxt      = ei_h_r;
    ei_c_nxt      = ei_c_r;
    ej_h_nxt      = ej_h_r;
    ej_c_nxt      = ej_c_r;
    ej_bp_nxt     = ej_bp_r;
    sqi_nxt       = sqi_r;
    sqj_nxt       = sqj_r;
    bpn_nxt       = bpn_r;
    m_ge_nxt      = m_ge_r;
    cmp_a_nxt     = cmp_a_r;
    pop           = 1'b0;
    raddr         = '0;
    waddr         = '0;
    we_all        = 1'b0;
    we_bp         = 1'b0;
    wh            = rd_h_r;
    wc            = rd_c_r;
    wbp           = rd_bp_r;
    div_req.start = 1'b0;
    div_req.num   = $signed({{(BP_W-COST_W){1'b0}}, ei_c_r})
                  - $signed({{(BP_W-COST_W){1'b0}}, ej_c_r})
                  + $signed({{(BP_W-SQ_W){1'b0}}, sqi_r})
                  - $signed({{(BP_W-SQ_W){1'b0}}, sqj_r});
    div_req.den   = $signed({hdiff, 1'b0});

    case (state_r)
      // take the next item
      S_IDLE: begin
        if (q.valid) begin
          pop   = 1'b1;
          h_nxt = q.item.height;
          if (q.item.restart || count_r == '0) begin
            count_nxt     = '0;
            ins_dp_nxt    = '0;
            k_nxt         = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            state_nxt     = S_F_RD;
          end else begin
            i_nxt     = '0;
            state_nxt = S_Q_RD;
          end
        end
      end
      // query scan: first breakpoint at or above the height
      S_Q_RD: begin
        raddr     = i_r;
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (({1'b0, i_r} + CNT_W'(1) < count_r) &&
            (rd_bp_r < $signed({{(BP_W-HEIGHT_W){1'b0}}, h_r}))) begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_Q_RD;
        end else begin
          d_nxt     = $signed({1'b0, h_r}) - $signed({1'b0, rd_h_r});
          cbase_nxt = rd_c_r;
          state_nxt = S_Q_MUL;
        end
      end
      S_Q_MUL: begin
        sq_nxt    = SQ_W'(dsq);
        state_nxt = S_Q_SUM;
      end
      // saturate and report
      S_Q_SUM: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.cost = sum[SUM_W-1] ? COST_MAX : sum[COST_W-1:0];
        out_data_nxt.overflow = (count_r >= CNT_W'(MAX_LINES));
        ins_dp_nxt = sum[SUM_W-1] ? COST_MAX : sum[COST_W-1:0];
        k_nxt      = '0;
        if (count_r >= CNT_W'(MAX_LINES)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      // insert position: after all entries of height at or below
      S_F_RD: begin
        if ({1'b0, k_r} == count_r) begin
          s_nxt     = count_r[IDX_W-1:0];
          state_nxt = S_SH;
        end else begin
          raddr     = k_r;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (rd_h_r <= h_r) begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_F_RD;
        end else begin
          s_nxt     = count_r[IDX_W-1:0];
          state_nxt = S_SH;
        end
      end
      // open a slot, moving the tail up one entry at a time
      S_SH: begin
        if (s_r == k_r) begin
          we_all    = 1'b1;
          waddr     = k_r;
          wh        = h_r;
          wc        = ins_dp_r;
          wbp       = '0;
          count_nxt = count_r + CNT_W'(1);
          y_nxt     = k_r;
          state_nxt = S_A_MEET;
        end else begin
          raddr     = s_r - IDX_W'(1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we_all    = 1'b1;
        waddr     = s_r;
        s_nxt     = s_r - IDX_W'(1);
        state_nxt = S_SH;
      end
      // breakpoint of entry mi against entry mj
      S_M_START: begin
        if (mj_r >= count_r) begin
          we_bp     = 1'b1;
          waddr     = mi_r;
          wbp       = BP_INF;
          m_ge_nxt  = 1'b0;
          state_nxt = ret_r;
        end else begin
          raddr     = mi_r;
          state_nxt = S_M_RI;
        end
      end
      S_M_RI: begin
        ei_h_nxt  = rd_h_r;
        ei_c_nxt  = rd_c_r;
        raddr     = mj_r[IDX_W-1:0];
        state_nxt = S_M_RJ;
      end
      S_M_RJ: begin
        ej_h_nxt  = rd_h_r;
        ej_c_nxt  = rd_c_r;
        ej_bp_nxt = rd_bp_r;
        state_nxt = S_M_CALC;
      end
      S_M_CALC: begin
        if (ei_h_r == ej_h_r) begin
          bpn_nxt   = (ei_c_r > ej_c_r) ? BP_INF : BP_NINF;
          state_nxt = S_M_FIN;
        end else begin
          sqi_nxt   = SQ_W'(ei_h_r * ei_h_r);
          sqj_nxt   = SQ_W'(ej_h_r * ej_h_r);
          state_nxt = S_M_NUM;
        end
      end
      S_M_NUM: begin
        div_req.start = 1'b1;
        state_nxt     = S_M_DIV;
      end
      S_M_DIV: begin
        if (div_rsp.done) begin
          bpn_nxt   = div_rsp.quo;
          state_nxt = S_M_FIN;
        end
      end
      S_M_FIN: begin
        we_bp     = 1'b1;
        waddr     = mi_r;
        wbp       = bpn_r;
        m_ge_nxt  = (bpn_r >= ej_bp_r);
        state_nxt = ret_r;
      end
      // remove entry p, moving the tail down
      S_D_LOOP: begin
        if ({1'b0, p_r} + CNT_W'(1) >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ret_r;
        end else begin
          raddr     = p_r + IDX_W'(1);
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        we_all    = 1'b1;
        waddr     = p_r;
        p_nxt     = p_r + IDX_W'(1);
        state_nxt = S_D_LOOP;
      end
      // prune to the right of the new entry
      S_A_MEET: begin
        mi_nxt    = y_r;
        mj_nxt    = {1'b0, y_r} + CNT_W'(1);
        ret_nxt   = S_A_CHK;
        state_nxt = S_M_START;
      end
      S_A_CHK: begin
        if (m_ge_r) begin
          p_nxt     = y_r + IDX_W'(1);
          ret_nxt   = S_A_MEET;
          state_nxt = S_D_LOOP;
        end else begin
          state_nxt = S_B_BEG;
        end
      end
      // is the new entry itself dominated
      S_B_BEG: begin
        if (y_r != '0) begin
          x_nxt     = y_r - IDX_W'(1);
          mi_nxt    = y_r - IDX_W'(1);
          mj_nxt    = {1'b0, y_r};
          ret_nxt   = S_B_CHK;
          state_nxt = S_M_START;
        end else begin
          x_nxt     = '0;
          state_nxt = S_C_BEG;
        end
      end
      S_B_CHK: begin
        if (m_ge_r) begin
          p_nxt     = y_r;
          ret_nxt   = S_B_M2;
          state_nxt = S_D_LOOP;
        end else begin
          state_nxt = S_C_BEG;
        end
      end
      S_B_M2: begin
        mi_nxt    = x_r;
        mj_nxt    = {1'b0, x_r} + CNT_W'(1);
        ret_nxt   = S_C_BEG;
        state_nxt = S_M_START;
      end
      // prune to the left while breakpoints fail to increase
      S_C_BEG: begin
        y_nxt = x_r;
        if (x_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          raddr     = x_r - IDX_W'(1);
          state_nxt = S_C_RB;
        end
      end
      S_C_RB: begin
        cmp_a_nxt = rd_bp_r;
        raddr     = y_r;
        state_nxt = S_C_CMP;
      end
      S_C_CMP: begin
        if (cmp_a_r < rd_bp_r) begin
          state_nxt = S_IDLE;
        end else begin
          x_nxt     = y_r - IDX_W'(1);
          p_nxt     = y_r;
          ret_nxt   = S_C_M;
          state_nxt = S_D_LOOP;
        end
      end
      S_C_M: begin
        mi_nxt    = x_r;
        mj_nxt    = {1'b0, x_r} + CNT_W'(1);
        ret_nxt   = S_C_BEG;
        state_nxt = S_M_START;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_all) begin
      hgt_mem[waddr] <= wh;
      cst_mem[waddr] <= wc;
    end
    if (we_all || we_bp) begin
      bp_mem[waddr] <= wbp;
    end
    rd_h_r  <= hgt_mem[raddr];
    rd_c_r  <= cst_mem[raddr];
    rd_bp_r <= bp_mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working values
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    h_r        <= h_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    s_r        <= s_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    p_r        <= p_nxt;
    mi_r       <= mi_nxt;
    mj_r       <= mj_nxt;
    d_r        <= d_nxt;
    cbase_r    <= cbase_nxt;
    sq_r       <= sq_nxt;
    ins_dp_r   <= ins_dp_nxt;
    ei_h_r     <= ei_h_nxt;
    ei_c_r     <= ei_c_nxt;
    ej_h_r     <= ej_h_nxt;
    ej_c_r     <= ej_c_nxt;
    ej_bp_r    <= ej_bp_nxt;
    sqi_r      <= sqi_nxt;
    sqj_r      <= sqj_nxt;
    bpn_r      <= bpn_nxt;
    m_ge_r     <= m_ge_nxt;
    cmp_a_r    <= cmp_a_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/quadratic_hull_dp_min.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_hull_dp_min - quadratic-cost hull minimizer
// cost[i] = min over earlier j of cost[j] + (h_j - h_i)^2 + step_cost,
// kept as a sorted store of parabolas with floored breakpoints.
//
//   channel  ports                          handshake
//   input    start, busy, in_data           taken when start && !busy
//   result   out_valid, out_data            one-cycle strobe, no stall
//   config   cfg_we, cfg_wdata              written when cfg_we
//
// An item's run time grows with the entries scanned by the query, the entries
// scanned for the insert slot, the entries moved by an insert or a removal,
// and the breakpoints evaluated, each through the bit-serial divider.
// The store has a single read and a single write port, which paces all walks.
// Reset is synchronous; the store needs no clearing pass, the entry count
// covers it. Two items queue ahead of the sequencer; busy is the queue full.
// ----------------------------------------------------------------------------
module quadratic_hull_dp_min import qhdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               in_data,
  output logic                   out_valid,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_wdata
);

  logic [STEP_W-1:0] step_cost_r;
  queue_t            q;
  logic              pop;

  // step cost register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cost_r <= '0;
    end else if (cfg_we) begin
      step_cost_r <= cfg_wdata;
    end
  end

  qhdm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .q       (q),
    .pop     (pop)
  );

  qhdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .pop       (pop),
    .step_cost (step_cost_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/qhdm_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhdm_chk - port-level checker
// Tracks items in flight from the ports and checks result and busy timing.
// ----------------------------------------------------------------------------
module qhdm_chk import qhdm_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  logic [2:0] pend_r;
  logic       acc;

  assign acc = start && !busy;

  // items accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + (acc ? 3'd1 : 3'd0) - (out_valid ? 3'd1 : 3'd0);
    end
  end

  // no result without an item waiting for one
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a pending item");

  // busy only with at least two items in flight
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> pend_r >= 3'd2)
    else $error("busy with fewer than two items pending");

  // bounded in-flight count
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("too many items in flight");

  // a strobed result carries known data
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result with unknown data");

  // quiet out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind quadratic_hull_dp_min qhdm_chk u_chk (.*);
`default_nettype wire

// ----- test/quadratic_hull_dp_min_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_hull_dp_min_checker - result predictor and scoreboard
// Watches the item, result and register channels of the hull minimizer.
// It keeps its own sorted store of parabolas, predicts cost and overflow for
// every accepted item and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module quadratic_hull_dp_min_checker import qhdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire in_t               in_data,
  input  wire logic              out_valid,
  input  wire out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_wdata,
  output int                     errors,
  output int                     pending
);

  localparam longint PINF = 64'sh7fff_ffff_ffff_ffff;
  localparam longint NINF = -PINF;

  // parabola store, kept sorted by height
  longint            hull_h  [MAX_LINES];
  longint            hull_c  [MAX_LINES];
  longint            hull_bp [MAX_LINES];
  int                hull_n;
  logic [STEP_W-1:0] step_cost;
  out_t              cost_due[$];

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q -= 1;
    return q;
  endfunction

  // breakpoint of entry i against entry j; true if it is at or above j's
  function automatic bit set_bp(int i, int j);
    longint num;
    if (j >= hull_n) begin
      hull_bp[i] = PINF;
      return 0;
    end
    if (hull_h[i] == hull_h[j]) begin
      hull_bp[i] = (hull_c[i] > hull_c[j]) ? PINF : NINF;
    end else begin
      num = (hull_c[i] - hull_c[j]) + (hull_h[i] * hull_h[i] - hull_h[j] * hull_h[j]);
      hull_bp[i] = floor_div(num, 2 * (hull_h[i] - hull_h[j]));
    end
    return hull_bp[i] >= hull_bp[j];
  endfunction

  function automatic void remove_at(int i);
    for (int m = i; m < hull_n - 1; m++) begin
      hull_h[m]  = hull_h[m+1];
      hull_c[m]  = hull_c[m+1];
      hull_bp[m] = hull_bp[m+1];
    end
    hull_n--;
  endfunction

  function automatic void add_parabola(longint dp, longint h);
    int k;
    int x;
    int y;
    k = 0;
    while (k < hull_n && hull_h[k] <= h) k++;
    for (int m = hull_n; m > k; m--) begin
      hull_h[m]  = hull_h[m-1];
      hull_c[m]  = hull_c[m-1];
      hull_bp[m] = hull_bp[m-1];
    end
    hull_h[k]  = h;
    hull_c[k]  = dp;
    hull_bp[k] = 0;
    hull_n++;
    y = k;
    while (set_bp(y, y + 1)) remove_at(y + 1);
    x = y;
    if (x != 0) begin
      x--;
      if (set_bp(x, y)) begin
        remove_at(y);
        void'(set_bp(x, x + 1));
      end
    end
    forever begin
      y = x;
      if (y == 0) break;
      x--;
      if (hull_bp[x] < hull_bp[y]) break;
      remove_at(y);
      void'(set_bp(x, x + 1));
    end
  endfunction

  function automatic out_t predict_cost(in_t it);
    out_t   r;
    int     i;
    longint h;
    longint d;
    logic [63:0] sum;
    h = longint'(it.height);
    r = '0;
    if (it.start_req || hull_n == 0) begin
      hull_n = 0;
      add_parabola(0, h);
      return r;
    end
    i = 0;
    while (i + 1 < hull_n && hull_bp[i] < h) i++;
    d   = h - hull_h[i];
    sum = 64'(d * d) + 64'(hull_c[i]) + 64'(step_cost);
    if (sum > 64'(COST_MAX)) sum = 64'(COST_MAX);
    r.cost = sum[COST_W-1:0];
    if (hull_n >= MAX_LINES) r.overflow = 1'b1;
    else add_parabola(longint'(sum), h);
    return r;
  endfunction

  // scoreboard
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      hull_n    = 0;
      step_cost = '0;
      cost_due.delete();
      errors    = 0;
    end else begin
      if (out_valid) begin
        if (cost_due.size() == 0) begin
          $display("%0t: unexpected item cost=%h ovf=%b", $time,
                   out_data.cost, out_data.overflow);
          errors++;
        end else begin
          want = cost_due.pop_front();
          if (out_data.cost !== want.cost) begin
            $display("%0t: cost expected %h actual %h", $time, want.cost, out_data.cost);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time,
                     want.overflow, out_data.overflow);
            errors++;
          end
        end
      end
      if (start && !busy) cost_due.push_back(predict_cost(in_data));
      if (cfg_we) step_cost = cfg_wdata;
    end
    pending = cost_due.size();
  end

endmodule

// ----- test/quadratic_hull_dp_min_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_hull_dp_min_test - top of the hull minimizer bench
// Drives directed and random height sequences under several step costs,
// including a run that fills the store, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module quadratic_hull_dp_min_test;
  import qhdm_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     DRAIN_WAIT  = 8000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_data;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  int                errors;
  int                pending;
  bit                idle_on;
  longint            cycles;

  quadratic_hull_dp_min u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  quadratic_hull_dp_min_checker u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("quadratic_hull_dp_min_test: errors");
        $finish;
      end
    end
  end

  // offer one item, with random idle cycles ahead of it when idle_on is set
  task automatic send_height(input logic s, input logic [HEIGHT_W-1:0] h);
    while (idle_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{start_req: s, height: h};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_step(input logic [STEP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random sequences: mostly narrow height windows, some full range
  task automatic random_phase(input int n);
    int          span;
    int          base;
    logic [HEIGHT_W-1:0] h;
    span = 16;
    base = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(19) == 0) begin
        case ($urandom_range(3))
          0: span = 4;
          1: span = 64;
          2: span = 4096;
          default: span = 1 << HEIGHT_W;
        endcase
        base = $urandom_range((1 << HEIGHT_W) - span);
        h = HEIGHT_W'(base + $urandom_range(span - 1));
        send_height(($urandom_range(7) != 0), h);
      end else begin
        h = HEIGHT_W'(base + $urandom_range(span - 1));
        send_height(1'b0, h);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store without start, extremes, equal heights
    send_height(1'b0, 20'd5);
    send_height(1'b0, '1);
    send_height(1'b0, '1);
    send_height(1'b0, '0);
    send_height(1'b1, '0);
    send_height(1'b0, '0);
    send_height(1'b0, '0);
    send_height(1'b0, 20'd3);
    send_height(1'b0, 20'd3);
    send_height(1'b0, '1);
    send_height(1'b1, '1);
    send_height(1'b0, 20'h55555);
    send_height(1'b0, 20'haaaaa);
    set_step('1);
    send_height(1'b1, 20'd100);
    send_height(1'b0, 20'd100);
    send_height(1'b0, 20'd0);
    send_height(1'b0, '1);
    send_height(1'b0, 20'd100);

    // fill the store past its capacity
    send_height(1'b1, '0);
    for (int k = 1; k <= MAX_LINES + 6; k++) send_height(1'b0, HEIGHT_W'(k));

    // random phases under several step costs
    set_step('0);
    random_phase(225);
    set_step(STEP_W'(17));
    idle_on = 1'b0;
    random_phase(150);
    idle_on = 1'b1;
    random_phase(75);
    drain();
    set_step(STEP_W'({$urandom(), $urandom()}));
    random_phase(225);
    set_step('1);
    random_phase(225);

    drain();
    if (errors == 0) begin
      $display("quadratic_hull_dp_min_test: clean");
    end else begin
      $display("quadratic_hull_dp_min_test: errors");
    end
    $finish;
  end

endmodule
